// ----- rtl/tcw_pkg.sv -----
// Shared types and constants of the text console cell writer.
`default_nettype none

package tcw_pkg;

  localparam int REQ_W  = 2;
  localparam int CHAR_W = 8;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int ATTR_W = 8;
  localparam int CELL_W = 16;

  localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;
  localparam logic [CELL_W-1:0] CELL_RESET = 16'h0020;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_PUT,
    CMD_NEWLINE,
    CMD_RETURN,
    CMD_BACKSPACE,
    CMD_TAB,
    CMD_READ,
    CMD_CLEAR
  } tcw_cmd_t;

  typedef struct packed {
    tcw_cmd_t          cmd;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              read_ok;
  } tcw_req_t;

endpackage

`default_nettype wire

// ----- rtl/tcw_ram.sv -----
// Generic single-port RAM with registered read data.
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 3200
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ----- rtl/tcw_front.sv -----
// Front end: classifies incoming requests and queues them for the back end.
`default_nettype none

module tcw_front #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [tcw_pkg::REQ_W-1:0]    req_type,
  input  wire logic [tcw_pkg::CHAR_W-1:0]   char_code,
  input  wire logic [tcw_pkg::ROW_W-1:0]    read_row,
  input  wire logic [tcw_pkg::COL_W-1:0]    read_col,
  input  wire logic                         init_busy,
  output logic                              q_valid,
  output tcw_pkg::tcw_req_t                 head,
  input  wire logic                         q_pop
);

  import tcw_pkg::*;

  localparam int QDEPTH = 2;

  tcw_req_t   q [QDEPTH];
  tcw_req_t   entry;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  always_comb begin
    entry.ch      = char_code;
    entry.row     = read_row;
    entry.col     = read_col;
    entry.read_ok = ({1'b0, read_row} < (ROW_W + 1)'(ROWS)) &&
                    ({1'b0, read_col} < (COL_W + 1)'(COLS));
    unique case (req_type)
      REQ_PUT: begin
        priority if (char_code == CH_NL) begin
          entry.cmd = CMD_NEWLINE;
        end else if (char_code == CH_CR) begin
          entry.cmd = CMD_RETURN;
        end else if (char_code == CH_BS) begin
          entry.cmd = CMD_BACKSPACE;
        end else if (char_code == CH_TAB) begin
          entry.cmd = CMD_TAB;
        end else begin
          entry.cmd = CMD_PUT;
        end
      end
      REQ_READ:  entry.cmd = CMD_READ;
      REQ_CLEAR: entry.cmd = CMD_CLEAR;
      default:   entry.cmd = CMD_NOP;
    endcase
  end

  assign busy    = (count == 2'(QDEPTH)) || init_busy;
  assign push    = start && !busy;
  assign q_valid = (count != 2'd0);
  assign head    = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("request queue popped while empty");

endmodule

`default_nettype wire

// ----- rtl/tcw_back.sv -----
// Back end: carries out queued requests on the screen store and the cursor.
`default_nettype none

module tcw_back #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         q_valid,
  input  wire tcw_pkg::tcw_req_t            head,
  output logic                              q_pop,
  output logic                              init_busy,
  input  wire logic                         cfg_valid,
  input  wire logic [tcw_pkg::ATTR_W-1:0]   cfg_data,
  output logic                              done,
  output logic      [tcw_pkg::CELL_W-1:0]   cell_data,
  output logic      [tcw_pkg::COL_W-1:0]    cursor_col,
  output logic      [tcw_pkg::ROW_W-1:0]    cursor_row
);

  import tcw_pkg::*;

  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW    = $clog2(COLS);
  localparam int AW    = RW + CW;
  localparam int DEPTH = ROWS << CW;

  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_COL = CW'(COLS - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_TAB    = 3'd2;
  localparam logic [2:0] S_SCROLL = 3'd3;
  localparam logic [2:0] S_CLEAR  = 3'd4;
  localparam logic [2:0] S_READ   = 3'd5;

  logic [2:0]        state, state_next;
  logic [CW-1:0]     cur_col, cur_col_next;
  logic [RW-1:0]     cur_row, cur_row_next;
  logic [RW-1:0]     base, base_next;
  logic [RW-1:0]     sweep_row, sweep_row_next;
  logic [CW-1:0]     sweep_col, sweep_col_next;
  logic [RW-1:0]     scroll_row, scroll_row_next;
  logic              init_pass, init_pass_next;
  logic [ATTR_W-1:0] attr;
  tcw_req_t          req, req_next;

  logic              emit;
  logic              next_line;
  logic [CELL_W-1:0] data_next;
  logic [CELL_W-1:0] blank;
  logic [CW-1:0]     col_inc;
  logic [RW-1:0]     cur_phys;
  logic              at_last_col;
  logic              at_last_row;

  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [CELL_W-1:0] ram_wdata;
  logic [CELL_W-1:0] ram_rdata;

  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] r,
                                             input logic [RW-1:0] b);
    logic [RW:0] s;
    s = {1'b0, r} + {1'b0, b};
    if (s >= (RW + 1)'(ROWS)) begin
      s = s - (RW + 1)'(ROWS);
    end
    return s[RW-1:0];
  endfunction

  tcw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(DEPTH)
  ) u_screen (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  assign blank       = {attr, CH_SPACE};
  assign col_inc     = cur_col + 1'b1;
  assign cur_phys    = phys_row(cur_row, base);
  assign at_last_col = (cur_col == LAST_COL);
  assign at_last_row = (cur_row == LAST_ROW);
  assign init_busy   = init_pass;

  always_comb begin
    state_next      = state;
    cur_col_next    = cur_col;
    cur_row_next    = cur_row;
    base_next       = base;
    sweep_row_next  = sweep_row;
    sweep_col_next  = sweep_col;
    scroll_row_next = scroll_row;
    init_pass_next  = init_pass;
    req_next        = req;
    q_pop           = 1'b0;
    emit            = 1'b0;
    next_line       = 1'b0;
    data_next       = '0;
    ram_we          = 1'b0;
    ram_addr        = {cur_phys, cur_col};
    ram_wdata       = blank;

    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          req_next   = head;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (req.cmd)
          CMD_PUT: begin
            ram_we    = 1'b1;
            ram_wdata = {attr, req.ch};
            if (at_last_col) begin
              next_line = 1'b1;
            end else begin
              cur_col_next = col_inc;
              emit         = 1'b1;
              state_next   = S_IDLE;
            end
          end
          CMD_NEWLINE: begin
            next_line = 1'b1;
          end
          CMD_RETURN: begin
            cur_col_next = '0;
            emit         = 1'b1;
            state_next   = S_IDLE;
          end
          CMD_BACKSPACE: begin
            if (cur_col != '0) begin
              cur_col_next = cur_col - 1'b1;
              ram_we       = 1'b1;
              ram_addr     = {cur_phys, cur_col - 1'b1};
            end
            emit       = 1'b1;
            state_next = S_IDLE;
          end
          CMD_TAB: begin
            state_next = S_TAB;
          end
          CMD_READ: begin
            if (req.read_ok) begin
              ram_addr   = {phys_row(RW'(req.row), base), CW'(req.col)};
              state_next = S_READ;
            end else begin
              emit       = 1'b1;
              state_next = S_IDLE;
            end
          end
          CMD_CLEAR: begin
            cur_col_next   = '0;
            cur_row_next   = '0;
            base_next      = '0;
            sweep_row_next = '0;
            sweep_col_next = '0;
            state_next     = S_CLEAR;
          end
          default: begin
            emit       = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end
      S_TAB: begin
        ram_we    = 1'b1;
        ram_wdata = blank;
        if (at_last_col) begin
          next_line = 1'b1;
        end else begin
          cur_col_next = col_inc;
          if (col_inc[1:0] == 2'd0) begin
            emit       = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_SCROLL: begin
        ram_we   = 1'b1;
        ram_addr = {scroll_row, sweep_col};
        if (sweep_col == LAST_COL) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end else begin
          sweep_col_next = sweep_col + 1'b1;
        end
      end
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = {sweep_row, sweep_col};
        ram_wdata = init_pass ? CELL_RESET : blank;
        if (sweep_col == LAST_COL) begin
          sweep_col_next = '0;
          if (sweep_row == LAST_ROW) begin
            emit           = !init_pass;
            init_pass_next = 1'b0;
            state_next     = S_IDLE;
          end else begin
            sweep_row_next = sweep_row + 1'b1;
          end
        end else begin
          sweep_col_next = sweep_col + 1'b1;
        end
      end
      S_READ: begin
        data_next  = ram_rdata;
        emit       = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (next_line) begin
      cur_col_next = '0;
      if (at_last_row) begin
        scroll_row_next = base;
        base_next       = (base == LAST_ROW) ? '0 : base + 1'b1;
        sweep_col_next  = '0;
        state_next      = S_SCROLL;
      end else begin
        cur_row_next = cur_row + 1'b1;
        emit         = 1'b1;
        state_next   = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cur_col   <= '0;
      cur_row   <= '0;
      base      <= '0;
      sweep_row <= '0;
      sweep_col <= '0;
      init_pass <= 1'b1;
      attr      <= ATTR_RESET;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      cur_col   <= cur_col_next;
      cur_row   <= cur_row_next;
      base      <= base_next;
      sweep_row <= sweep_row_next;
      sweep_col <= sweep_col_next;
      init_pass <= init_pass_next;
      done      <= emit;
      if (cfg_valid) begin
        attr <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    req        <= req_next;
    scroll_row <= scroll_row_next;
    if (emit) begin
      cell_data  <= data_next;
      cursor_col <= COL_W'(cur_col_next);
      cursor_row <= ROW_W'(cur_row_next);
    end
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_clear_home: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> (cur_row == '0) && (cur_col == '0) && (base == '0))
    else $error("cursor not home during a clearing pass");

  a_scroll_bottom: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCROLL) |-> at_last_row && (cur_col == '0))
    else $error("scroll without the cursor on the bottom row");

  a_init_no_work: assert property (@(posedge clk) disable iff (rst)
    init_pass |-> !q_valid && !done)
    else $error("request seen during the power-up clearing pass");

  a_base_range: assert property (@(posedge clk) disable iff (rst)
    done |-> ({1'b0, base} < (RW + 1)'(ROWS)) && ({1'b0, cur_row} < (RW + 1)'(ROWS)))
    else $error("row offset or cursor row out of range");

endmodule

`default_nettype wire

// ----- rtl/text_console_cell_writer.sv -----
// Top level of the text console cell writer.
//
// Channel   Direction  Handshake                 Payload
// request   in         start, busy               req_type, char_code, read_row, read_col
// config    in         cfg_valid, cfg_ready      cfg_data (text attribute)
// result    out        done (one-cycle strobe)   cell_data, cursor_col, cursor_row
//
// With the queue empty and the back end idle, a put, return, newline, backspace, unused or
// out-of-range read request passes the queue, the back end's S_IDLE and S_EXEC states and the
// done register; a read of a valid cell also passes S_READ for the registered RAM data, and
// a tab passes S_TAB once per padding cell, up to the next tab stop at a multiple of four.
// The single screen RAM port moves one cell a cycle. A scroll also blanks the new bottom
// row and a clear every cell. A request behind another in the queue also waits for that one.
// After reset a clearing pass holds busy high; configuration writes are taken throughout.
// The result side cannot stall; a two-entry queue decouples the request side, which sees
// busy only when the queue is full or the clearing pass runs.
`default_nettype none

module text_console_cell_writer #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [tcw_pkg::REQ_W-1:0]    req_type,
  input  wire logic [tcw_pkg::CHAR_W-1:0]   char_code,
  input  wire logic [tcw_pkg::ROW_W-1:0]    read_row,
  input  wire logic [tcw_pkg::COL_W-1:0]    read_col,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [tcw_pkg::ATTR_W-1:0]   cfg_data,
  output logic                              done,
  output logic      [tcw_pkg::CELL_W-1:0]   cell_data,
  output logic      [tcw_pkg::COL_W-1:0]    cursor_col,
  output logic      [tcw_pkg::ROW_W-1:0]    cursor_row
);

  import tcw_pkg::*;

  tcw_req_t head;
  logic     q_valid;
  logic     q_pop;
  logic     init_busy;

  assign cfg_ready = 1'b1;

  tcw_front #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req_type (req_type),
    .char_code(char_code),
    .read_row (read_row),
    .read_col (read_col),
    .init_busy(init_busy),
    .q_valid  (q_valid),
    .head     (head),
    .q_pop    (q_pop)
  );

  tcw_back #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .head      (head),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .done      (done),
    .cell_data (cell_data),
    .cursor_col(cursor_col),
    .cursor_row(cursor_row)
  );

endmodule

`default_nettype wire
